/* rtl/core/htgb_pkg.sv */
// Hill terrain grid builder: shared types, codes and constants.
// Used by htgb_alu, htgb_seq and the top-level module; depends on nothing.
package htgb_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_SEED  = 2'd1,
        CMD_SAND  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ALU_ZERO    = 2'd0,
        ALU_SET1    = 2'd1,
        ALU_SAT_INC = 2'd2
    } t_alu_op;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_CTR,
        ST_CHK,
        ST_FIN,
        ST_RES
    } t_state;

    typedef struct packed {
        t_cmd       cmd;
        logic [6:0] col;
        logic [6:0] row;
    } t_req;

    typedef struct packed {
        logic       applied;
        logic [7:0] height;
        logic [2:0] terrain_class;
    } t_res;

    typedef struct packed {
        logic [7:0] grid_width;
        logic [7:0] grid_height;
        logic [7:0] height_cap;
    } t_cfg;

    typedef struct packed {
        logic [7:0] new_val;
        logic       changed;
    } t_alu_res;

    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_HEIGHT_CAP  = 2'd2;

    localparam logic [7:0] RESET_SIDE = 8'd100;
    localparam logic [7:0] RESET_CAP  = 8'd100;

    localparam logic [7:0] BEACH_TOP = 8'd3;
    localparam logic [7:0] TREES_TOP = 8'd15;
    localparam logic [7:0] DENSE_TOP = 8'd20;

    localparam logic [2:0] TC_WATER = 3'd0;
    localparam logic [2:0] TC_BEACH = 3'd1;
    localparam logic [2:0] TC_TREES = 3'd2;
    localparam logic [2:0] TC_DENSE = 3'd3;
    localparam logic [2:0] TC_ROCK  = 3'd4;

    function automatic logic [2:0] terrain_of(input logic [7:0] h);
        logic [2:0] tc;
        if (h == 8'd0) begin
            tc = TC_WATER;
        end else if (h <= BEACH_TOP) begin
            tc = TC_BEACH;
        end else if (h <= TREES_TOP) begin
            tc = TC_TREES;
        end else if (h <= DENSE_TOP) begin
            tc = TC_DENSE;
        end else begin
            tc = TC_ROCK;
        end
        return tc;
    endfunction

endpackage

/* rtl/core/htgb_ram.sv */
// Height grid store: one write port, one registered read port.
// Depends on nothing.
module htgb_ram #(
    parameter int AW = 14
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    output logic [7:0]    o_rd_data
);

    logic [7:0] mem [2**AW];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/htgb_alu.sv */
// Shared cell update unit: zero, set to one, or saturating increment.
// Depends on htgb_pkg.
module htgb_alu (
    input  htgb_pkg::t_alu_op  i_op,
    input  logic [7:0]         i_old,
    input  logic [7:0]         i_cap,
    output htgb_pkg::t_alu_res o_res
);

    logic [8:0] sum;
    logic [7:0] nv;

    assign sum = {1'b0, i_old} + 9'd1;

    always_comb begin
        case (i_op)
            htgb_pkg::ALU_ZERO:    nv = 8'd0;
            htgb_pkg::ALU_SET1:    nv = 8'd1;
            htgb_pkg::ALU_SAT_INC: nv = (sum > {1'b0, i_cap}) ? i_cap : sum[7:0];
            default:               nv = i_old;
        endcase
    end

    assign o_res.new_val = nv;
    assign o_res.changed = (nv != i_old);

endmodule

/* rtl/core/htgb_seq.sv */
// Sequencer: clearing pass, area and 3x3 sweeps, seed and target reads.
// Depends on htgb_pkg, htgb_ram and htgb_alu.
module htgb_seq #(
    parameter int MAX_SIDE = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  htgb_pkg::t_req i_req,
    input  htgb_pkg::t_cfg i_cfg,
    output logic           o_busy,
    output logic           o_done,
    output htgb_pkg::t_res o_res
);

    localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int AW = 2 * CW;
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int XW = (SW > 8) ? SW : 8;

    htgb_pkg::t_state   r_state, n_state;
    htgb_pkg::t_cmd     r_cmd;
    htgb_pkg::t_alu_op  r_op;
    htgb_pkg::t_alu_res alu_res;

    logic [XW-1:0] w_side, h_side, req_col, req_row;
    logic [XW-1:0] r_col, r_row, r_x, r_y, r_x0, r_x1, r_y1;
    logic [AW-1:0] r_pend_addr, r_init_addr, ctr_addr, swp_addr;
    logic          r_pend, r_inside, r_changed;
    logic          accept, in_area, interior, swp_last;

    logic          ram_rd_en, ram_we;
    logic [AW-1:0] ram_rd_addr, ram_wr_addr;
    logic [7:0]    ram_wr_data, rd_data, res_h;

    function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                                input logic [XW-1:0] y);
        return {y[CW-1:0], x[CW-1:0]};
    endfunction

    assign w_side = (XW'(i_cfg.grid_width) > XW'(MAX_SIDE)) ? XW'(MAX_SIDE)
                                                             : XW'(i_cfg.grid_width);
    assign h_side = (XW'(i_cfg.grid_height) > XW'(MAX_SIDE)) ? XW'(MAX_SIDE)
                                                              : XW'(i_cfg.grid_height);
    assign req_col = XW'(i_req.col);
    assign req_row = XW'(i_req.row);

    assign in_area  = (req_col < w_side) && (req_row < h_side);
    assign interior = (w_side >= XW'(3)) && (h_side >= XW'(3))
                   && (req_col >= XW'(1)) && (req_row >= XW'(1))
                   && ((req_col + XW'(1)) < w_side) && ((req_row + XW'(1)) < h_side);

    assign accept   = i_start && (r_state == htgb_pkg::ST_IDLE);
    assign ctr_addr = cell_addr(r_col, r_row);
    assign swp_addr = cell_addr(r_x, r_y);
    assign swp_last = (r_x == r_x1) && (r_y == r_y1);

    htgb_ram #(.AW(AW)) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .o_rd_data (rd_data)
    );

    htgb_alu u_alu (
        .i_op  (r_op),
        .i_old (rd_data),
        .i_cap (i_cfg.height_cap),
        .o_res (alu_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            htgb_pkg::ST_INIT: begin
                if (r_init_addr == {AW{1'b1}}) n_state = htgb_pkg::ST_IDLE;
            end
            htgb_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (i_req.cmd)
                        htgb_pkg::CMD_CLEAR: begin
                            n_state = (w_side == '0 || h_side == '0) ? htgb_pkg::ST_FIN
                                                                     : htgb_pkg::ST_SWEEP;
                        end
                        htgb_pkg::CMD_SEED,
                        htgb_pkg::CMD_SAND: begin
                            n_state = interior ? htgb_pkg::ST_CTR : htgb_pkg::ST_FIN;
                        end
                        default: n_state = htgb_pkg::ST_FIN;
                    endcase
                end
            end
            htgb_pkg::ST_CTR: n_state = htgb_pkg::ST_CHK;
            htgb_pkg::ST_CHK: begin
                n_state = (r_cmd == htgb_pkg::CMD_SAND && rd_data != 8'd0)
                        ? htgb_pkg::ST_SWEEP : htgb_pkg::ST_FIN;
            end
            htgb_pkg::ST_SWEEP: begin
                if (swp_last) n_state = htgb_pkg::ST_DRAIN;
            end
            htgb_pkg::ST_DRAIN: n_state = htgb_pkg::ST_FIN;
            htgb_pkg::ST_FIN:   n_state = htgb_pkg::ST_RES;
            htgb_pkg::ST_RES:   n_state = htgb_pkg::ST_IDLE;
            default:            n_state = htgb_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = ctr_addr;
        ram_we      = 1'b0;
        ram_wr_addr = ctr_addr;
        ram_wr_data = alu_res.new_val;
        o_busy      = (r_state != htgb_pkg::ST_IDLE);
        o_done      = 1'b0;
        case (r_state)
            htgb_pkg::ST_INIT: begin
                ram_we      = 1'b1;
                ram_wr_addr = r_init_addr;
                ram_wr_data = 8'd0;
            end
            htgb_pkg::ST_SWEEP: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = swp_addr;
                ram_we      = r_pend && alu_res.changed;
                ram_wr_addr = r_pend_addr;
            end
            htgb_pkg::ST_DRAIN: begin
                ram_we      = r_pend && alu_res.changed;
                ram_wr_addr = r_pend_addr;
            end
            htgb_pkg::ST_CTR,
            htgb_pkg::ST_FIN: begin
                ram_rd_en = 1'b1;
            end
            htgb_pkg::ST_CHK: begin
                ram_we = (r_cmd == htgb_pkg::CMD_SEED) && alu_res.changed;
            end
            htgb_pkg::ST_RES: begin
                o_done = 1'b1;
            end
            default: ;
        endcase
    end

    assign res_h               = r_inside ? rd_data : 8'd0;
    assign o_res.applied       = r_changed;
    assign o_res.height        = res_h;
    assign o_res.terrain_class = htgb_pkg::terrain_of(res_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= htgb_pkg::ST_INIT;
            r_init_addr <= '0;
            r_pend      <= 1'b0;
            r_changed   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == htgb_pkg::ST_SWEEP);
            if (r_state == htgb_pkg::ST_INIT) begin
                r_init_addr <= r_init_addr + AW'(1);
            end
            if (accept) begin
                r_changed <= 1'b0;
            end else if (ram_we && r_state != htgb_pkg::ST_INIT) begin
                r_changed <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= swp_addr;
        if (accept) begin
            r_cmd    <= i_req.cmd;
            r_col    <= req_col;
            r_row    <= req_row;
            r_inside <= in_area;
            case (i_req.cmd)
                htgb_pkg::CMD_CLEAR: r_op <= htgb_pkg::ALU_ZERO;
                htgb_pkg::CMD_SEED:  r_op <= htgb_pkg::ALU_SET1;
                default:             r_op <= htgb_pkg::ALU_SAT_INC;
            endcase
            if (i_req.cmd == htgb_pkg::CMD_CLEAR) begin
                r_x  <= '0;
                r_y  <= '0;
                r_x0 <= '0;
                r_x1 <= w_side - XW'(1);
                r_y1 <= h_side - XW'(1);
            end else begin
                r_x  <= req_col - XW'(1);
                r_y  <= req_row - XW'(1);
                r_x0 <= req_col - XW'(1);
                r_x1 <= req_col + XW'(1);
                r_y1 <= req_row + XW'(1);
            end
        end else if (r_state == htgb_pkg::ST_SWEEP) begin
            if (r_x == r_x1) begin
                r_x <= r_x0;
                r_y <= r_y + XW'(1);
            end else begin
                r_x <= r_x + XW'(1);
            end
        end
    end

endmodule

/* rtl/core/hill_terrain_grid_builder.sv */
// Hill terrain grid builder, top level: config registers, result register.
// One request at a time; busy falls as the result is shown. Result has no stall.
// After reset a clearing pass zeroes every cell, one per cycle, over all
// 4**ceil(log2(MAX_SIDE)) addresses (16384 by default); config writes still taken.
module hill_terrain_grid_builder #(
    parameter int MAX_SIDE = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  htgb_pkg::t_req i_req,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [7:0]     i_cfg_data,
    output logic           o_res_valid,
    output htgb_pkg::t_res o_res
);

    htgb_pkg::t_cfg r_cfg;
    htgb_pkg::t_res r_res, seq_res;
    logic           r_res_valid, seq_done;

    htgb_seq #(.MAX_SIDE(MAX_SIDE)) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .i_cfg   (r_cfg),
        .o_busy  (busy),
        .o_done  (seq_done),
        .o_res   (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width  <= htgb_pkg::RESET_SIDE;
            r_cfg.grid_height <= htgb_pkg::RESET_SIDE;
            r_cfg.height_cap  <= htgb_pkg::RESET_CAP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                htgb_pkg::CFG_GRID_WIDTH:  r_cfg.grid_width  <= i_cfg_data;
                htgb_pkg::CFG_GRID_HEIGHT: r_cfg.grid_height <= i_cfg_data;
                htgb_pkg::CFG_HEIGHT_CAP:  r_cfg.height_cap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= seq_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_res <= seq_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench for hill_terrain_grid_builder: directed and random command streams,
// each result checked against a behavioural height-map model. Needs htgb_pkg.
module tb;

    localparam int SIDE         = 128;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int RANDOM_ITEMS = 1350;

    logic           i_clk      = 1'b0;
    logic           i_rst_n    = 1'b0;
    logic           start      = 1'b0;
    logic           busy;
    htgb_pkg::t_req i_req      = '0;
    logic           i_cfg_we   = 1'b0;
    logic [1:0]     i_cfg_idx  = '0;
    logic [7:0]     i_cfg_data = '0;
    logic           o_res_valid;
    htgb_pkg::t_res o_res;

    logic [7:0]     height_map [0:SIDE*SIDE-1];
    logic [7:0]     cfg_width;
    logic [7:0]     cfg_height;
    logic [7:0]     cfg_cap;
    htgb_pkg::t_res pending_reports [$];
    int             hot_cells [$];
    int             fail_count  = 0;
    int             cycle_count = 0;
    bit             no_idle     = 1'b0;

    hill_terrain_grid_builder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_check
        htgb_pkg::t_res want;
        if (i_rst_n && o_res_valid) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result: applied %0d height %0d class %0d",
                       o_res.applied, o_res.height, o_res.terrain_class);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                if (o_res.applied !== want.applied) begin
                    $error("applied: expected %0d, got %0d", want.applied, o_res.applied);
                    fail_count++;
                end
                if (o_res.height !== want.height) begin
                    $error("height: expected %0d, got %0d", want.height, o_res.height);
                    fail_count++;
                end
                if (o_res.terrain_class !== want.terrain_class) begin
                    $error("terrain_class: expected %0d, got %0d",
                           want.terrain_class, o_res.terrain_class);
                    fail_count++;
                end
            end
        end
    end

    function automatic int act_side(input logic [7:0] v);
        return (v > SIDE) ? SIDE : int'(v);
    endfunction

    function automatic logic [2:0] class_of(input logic [7:0] hv);
        if (hv > htgb_pkg::DENSE_TOP) return htgb_pkg::TC_ROCK;
        if (hv > htgb_pkg::TREES_TOP) return htgb_pkg::TC_DENSE;
        if (hv > htgb_pkg::BEACH_TOP) return htgb_pkg::TC_TREES;
        if (hv != 8'd0) return htgb_pkg::TC_BEACH;
        return htgb_pkg::TC_WATER;
    endfunction

    // updates the height map and returns the report for one request
    function automatic htgb_pkg::t_res model_command(input htgb_pkg::t_req rq);
        int             w, h, c, r, x, y, nv;
        bit             chg, interior;
        logic [7:0]     hv;
        htgb_pkg::t_res rs;
        w = act_side(cfg_width);
        h = act_side(cfg_height);
        c = int'(rq.col);
        r = int'(rq.row);
        chg = 1'b0;
        interior = w >= 3 && h >= 3 && c >= 1 && r >= 1 && c + 1 < w && r + 1 < h;
        case (rq.cmd)
            htgb_pkg::CMD_CLEAR: begin
                for (y = 0; y < h; y++) begin
                    for (x = 0; x < w; x++) begin
                        if (height_map[y*SIDE+x] != 8'd0) begin
                            height_map[y*SIDE+x] = 8'd0;
                            chg = 1'b1;
                        end
                    end
                end
            end
            htgb_pkg::CMD_SEED: begin
                if (interior && height_map[r*SIDE+c] != 8'd1) begin
                    height_map[r*SIDE+c] = 8'd1;
                    chg = 1'b1;
                end
            end
            htgb_pkg::CMD_SAND: begin
                if (interior && height_map[r*SIDE+c] != 8'd0) begin
                    for (y = r - 1; y <= r + 1; y++) begin
                        for (x = c - 1; x <= c + 1; x++) begin
                            nv = int'(height_map[y*SIDE+x]) + 1;
                            if (nv > int'(cfg_cap)) nv = int'(cfg_cap);
                            if (nv != int'(height_map[y*SIDE+x])) begin
                                height_map[y*SIDE+x] = nv[7:0];
                                chg = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        hv = (c < w && r < h) ? height_map[r*SIDE+c] : 8'd0;
        rs.applied = chg;
        rs.height = hv;
        rs.terrain_class = class_of(hv);
        return rs;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic issue_command(input htgb_pkg::t_cmd cmd, input int col, input int row);
        htgb_pkg::t_req rq;
        int             gap;
        rq.cmd = cmd;
        rq.col = col[6:0];
        rq.row = row[6:0];
        i_req <= rq;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_reports.push_back(model_command(rq));
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_reports();
        start <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            htgb_pkg::CFG_GRID_WIDTH: begin
                cfg_width = val;
            end
            htgb_pkg::CFG_GRID_HEIGHT: begin
                cfg_height = val;
            end
            htgb_pkg::CFG_HEIGHT_CAP: begin
                cfg_cap = val;
            end
            default: begin
            end
        endcase
        hot_cells.delete();
    endtask

    task automatic set_grid(input logic [7:0] w, input logic [7:0] h, input logic [7:0] cap);
        drain_reports();
        write_reg(htgb_pkg::CFG_GRID_WIDTH, w);
        write_reg(htgb_pkg::CFG_GRID_HEIGHT, h);
        write_reg(htgb_pkg::CFG_HEIGHT_CAP, cap);
    endtask

    function automatic int pick_interior(input int side);
        if (side < 3) return $urandom_range(0, SIDE - 1);
        return $urandom_range(1, side - 2);
    endfunction

    function automatic int near_cell(input int base, input int side);
        int v;
        v = base + int'($urandom_range(0, 2)) - 1;
        if (side < 3) return v & (SIDE - 1);
        if (v < 1) v = 1;
        if (v > side - 2) v = side - 2;
        return v;
    endfunction

    function automatic logic [7:0] pick_cap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 30) return 8'($urandom_range(1, 6));
        if (p < 70) return 8'($urandom_range(7, 40));
        if (p < 90) return 8'($urandom_range(41, 254));
        if (p < 95) return 8'd255;
        return 8'd0;
    endfunction

    // mostly seed-then-sand sequences around recently seeded cells, some noise
    task automatic random_command();
        int             w, h, p, c, r, hot_idx;
        bit             big;
        htgb_pkg::t_cmd cmd;
        w = act_side(cfg_width);
        h = act_side(cfg_height);
        big = (w * h) > 2048;
        p = $urandom_range(0, 99);
        c = pick_interior(w);
        r = pick_interior(h);
        if (p < 2) begin
            cmd = htgb_pkg::CMD_CLEAR;
            if (big && $urandom_range(0, 99) != 0) cmd = htgb_pkg::CMD_READ;
        end else if (p < 17) begin
            cmd = htgb_pkg::CMD_SEED;
            hot_cells.push_back(r * SIDE + c);
            if (hot_cells.size() > 12) void'(hot_cells.pop_front());
        end else if (p < 62) begin
            cmd = htgb_pkg::CMD_SAND;
            if (hot_cells.size() != 0 && $urandom_range(0, 9) < 8) begin
                hot_idx = hot_cells[$urandom_range(0, hot_cells.size() - 1)];
                c = near_cell(hot_idx % SIDE, w);
                r = near_cell(hot_idx / SIDE, h);
            end
        end else if (p < 85) begin
            cmd = htgb_pkg::CMD_READ;
            if (w > 0 && h > 0 && $urandom_range(0, 1) == 1) begin
                c = $urandom_range(0, w - 1);
                r = $urandom_range(0, h - 1);
            end
        end else begin
            cmd = htgb_pkg::t_cmd'(2'($urandom_range(0, 3)));
            if (cmd == htgb_pkg::CMD_CLEAR && big) cmd = htgb_pkg::CMD_READ;
            c = $urandom_range(0, SIDE - 1);
            r = $urandom_range(0, SIDE - 1);
        end
        issue_command(cmd, c, r);
    endtask

    task automatic test_reset_defaults();
        issue_command(htgb_pkg::CMD_READ, 99, 99);
        issue_command(htgb_pkg::CMD_READ, 100, 0);
        issue_command(htgb_pkg::CMD_SEED, 50, 50);
        issue_command(htgb_pkg::CMD_SEED, 50, 50);
        issue_command(htgb_pkg::CMD_SAND, 50, 50);
        issue_command(htgb_pkg::CMD_SAND, 51, 51);
        issue_command(htgb_pkg::CMD_SAND, 10, 10);
        issue_command(htgb_pkg::CMD_SEED, 99, 5);
    endtask

    task automatic test_extremes();
        set_grid(8'd255, 8'd128, 8'd255);
        issue_command(htgb_pkg::CMD_SEED, 126, 126);
        issue_command(htgb_pkg::CMD_SAND, 126, 126);
        issue_command(htgb_pkg::CMD_SAND, 127, 127);
        issue_command(htgb_pkg::CMD_SEED, 126, 126);
        issue_command(htgb_pkg::CMD_CLEAR, 0, 0);
        issue_command(htgb_pkg::CMD_READ, 126, 126);
    endtask

    task automatic test_cap_saturation();
        set_grid(8'd5, 8'd5, 8'd2);
        issue_command(htgb_pkg::CMD_SEED, 2, 2);
        issue_command(htgb_pkg::CMD_SAND, 2, 2);
        issue_command(htgb_pkg::CMD_SAND, 2, 2);
        issue_command(htgb_pkg::CMD_SAND, 2, 2);
        drain_reports();
        write_reg(htgb_pkg::CFG_HEIGHT_CAP, 8'd0);
        issue_command(htgb_pkg::CMD_SAND, 2, 2);
        drain_reports();
        write_reg(htgb_pkg::CFG_HEIGHT_CAP, 8'd1);
        issue_command(htgb_pkg::CMD_SEED, 2, 2);
        issue_command(htgb_pkg::CMD_SAND, 2, 2);
    endtask

    task automatic test_small_grid();
        set_grid(8'd2, 8'd5, 8'd10);
        issue_command(htgb_pkg::CMD_SEED, 1, 1);
        set_grid(8'd0, 8'd0, 8'd10);
        issue_command(htgb_pkg::CMD_CLEAR, 0, 0);
        set_grid(8'd200, 8'd3, 8'd255);
        issue_command(htgb_pkg::CMD_SEED, 126, 1);
        issue_command(htgb_pkg::CMD_SAND, 126, 1);
        issue_command(htgb_pkg::CMD_READ, 127, 2);
    endtask

    task automatic test_clear_outside();
        set_grid(8'd10, 8'd10, 8'd50);
        issue_command(htgb_pkg::CMD_SEED, 8, 8);
        issue_command(htgb_pkg::CMD_SAND, 8, 8);
        set_grid(8'd5, 8'd5, 8'd50);
        issue_command(htgb_pkg::CMD_CLEAR, 1, 1);
        issue_command(htgb_pkg::CMD_READ, 8, 8);
        set_grid(8'd10, 8'd10, 8'd50);
        issue_command(htgb_pkg::CMD_READ, 9, 9);
    endtask

    task automatic test_random_phases();
        int done, n, k, kind;
        logic [7:0] w, h;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                w = 8'($urandom_range(3, 12));
                h = 8'($urandom_range(3, 12));
            end else if (kind < 7) begin
                w = 8'($urandom_range(13, 40));
                h = 8'($urandom_range(13, 40));
            end else if (kind < 9) begin
                w = ($urandom_range(0, 2) == 0) ? 8'd128 : 8'($urandom_range(100, 255));
                h = ($urandom_range(0, 2) == 0) ? 8'd128 : 8'($urandom_range(100, 255));
            end else begin
                w = 8'($urandom_range(0, 4));
                h = 8'($urandom_range(0, 20));
            end
            set_grid(w, h, pick_cap());
            no_idle = ($urandom_range(0, 3) == 0);
            n = $urandom_range(40, 120);
            for (k = 0; k < n; k++) random_command();
            done += n;
        end
        no_idle = 1'b0;
        drain_reports();
    endtask

    initial begin
        for (int i = 0; i < SIDE * SIDE; i++) height_map[i] = 8'd0;
        cfg_width = htgb_pkg::RESET_SIDE;
        cfg_height = htgb_pkg::RESET_SIDE;
        cfg_cap = htgb_pkg::RESET_CAP;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_extremes();
        test_cap_saturation();
        test_small_grid();
        test_clear_outside();
        test_random_phases();
        drain_reports();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
